FILE: hdl/socks5_request_parser_assert.svh
// Assertion macros shared by the SOCKS5 request parser RTL.
`ifndef SOCKS5_REQUEST_PARSER_ASSERT_SVH
`define SOCKS5_REQUEST_PARSER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define S5RP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The condition must hold in the cycle after the trigger.
`define S5RP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/s5rp_pkg.sv
// Types and protocol constants of the SOCKS5 request parser.
`default_nettype none

package s5rp_pkg;

   // Parse phases
   localparam logic [3:0] PH_GREET_VER = 4'd0;
   localparam logic [3:0] PH_NMETHODS  = 4'd1;
   localparam logic [3:0] PH_METHODS   = 4'd2;
   localparam logic [3:0] PH_REQ_VER   = 4'd3;
   localparam logic [3:0] PH_REQ_CMD   = 4'd4;
   localparam logic [3:0] PH_REQ_RSV   = 4'd5;
   localparam logic [3:0] PH_ATYP      = 4'd6;
   localparam logic [3:0] PH_DLEN      = 4'd7;
   localparam logic [3:0] PH_ADDR      = 4'd8;
   localparam logic [3:0] PH_PORT_HI   = 4'd9;
   localparam logic [3:0] PH_PORT_LO   = 4'd10;

   // Result kinds
   localparam logic [1:0] KIND_REPLY = 2'd0;
   localparam logic [1:0] KIND_ADDR  = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   // Address types as reported
   localparam logic [1:0] ATYPE_IPV4   = 2'd0;
   localparam logic [1:0] ATYPE_DOMAIN = 2'd1;
   localparam logic [1:0] ATYPE_IPV6   = 2'd2;

   // Error causes
   localparam logic [2:0] CAUSE_GREET_VER  = 3'd0;
   localparam logic [2:0] CAUSE_NO_METHODS = 3'd1;
   localparam logic [2:0] CAUSE_REQUEST    = 3'd2;
   localparam logic [2:0] CAUSE_ATYP       = 3'd3;
   localparam logic [2:0] CAUSE_DOMAIN_LEN = 3'd4;

   // Wire-format bytes
   localparam logic [7:0] SOCKS_VER        = 8'h05;
   localparam logic [7:0] CMD_CONNECT      = 8'h01;
   localparam logic [7:0] ATYP_BYTE_IPV4   = 8'h01;
   localparam logic [7:0] ATYP_BYTE_DOMAIN = 8'h03;
   localparam logic [7:0] ATYP_BYTE_IPV6   = 8'h04;
   localparam logic [7:0] METHOD_NO_AUTH   = 8'h00;

   localparam logic [7:0] IPV4_ADDR_LEN    = 8'd4;
   localparam logic [7:0] IPV6_ADDR_LEN    = 8'd16;
   localparam logic [7:0] DOMAIN_LEN_RESET = 8'd255;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [1:0]  addr_type;
      logic [15:0] target_port;
      logic [2:0]  error_cause;
      logic        last;
   } rsp_item_type;

   // Results caused by one received byte, item0 first.
   typedef struct packed {
      logic [1:0]   push_count;
      rsp_item_type item0;
      rsp_item_type item1;
   } step_type;

   typedef struct packed {
      logic has_room;
      logic not_empty;
   } queue_status_type;

endpackage

`default_nettype wire

FILE: hdl/s5rp_req_if.sv
// Byte channel from the client connection into the parser.
`default_nettype none

interface s5rp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/s5rp_rsp_if.sv
// Result channel out of the parser.
`default_nettype none

interface s5rp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  data_byte;
   logic [1:0]  addr_type;
   logic [15:0] target_port;
   logic [2:0]  error_cause;
   logic        last;

   modport source (output valid, output kind, output data_byte, output addr_type,
                   output target_port, output error_cause, output last, input ready);
   modport sink (input valid, input kind, input data_byte, input addr_type,
                 input target_port, input error_cause, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/s5rp_csr_if.sv
// Write channel for the domain length limit register.
`default_nettype none

interface s5rp_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] max_domain_len;

   modport source (output valid, output max_domain_len, input ready);
   modport sink (input valid, input max_domain_len, output ready);
endinterface

`default_nettype wire

FILE: hdl/s5rp_parser.sv
// Handshake state machine: one received byte in, up to two results out.
`default_nettype none

module s5rp_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        rx_byte,
   input  wire logic [7:0]        max_domain_len,
   output s5rp_pkg::step_type     step
);
   import s5rp_pkg::*;

   logic [3:0] phase_ff, phase_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [1:0] address_kind_ff, address_kind_in;
   logic [7:0] port_high_ff, port_high_in;
   logic [7:0] remaining_dec;

   function automatic rsp_item_type make_item(logic [1:0] kind, logic [7:0] data,
                                              logic [1:0] atype, logic [15:0] port,
                                              logic [2:0] cause, logic last);
      rsp_item_type item;
      item.kind        = kind;
      item.data_byte   = data;
      item.addr_type   = atype;
      item.target_port = port;
      item.error_cause = cause;
      item.last        = last;
      return item;
   endfunction

   function automatic rsp_item_type make_error(logic [2:0] cause);
      return make_item(KIND_ERROR, 8'd0, ATYPE_IPV4, 16'd0, cause, 1'b1);
   endfunction

   assign remaining_dec = remaining_ff - 8'd1;

   always_comb begin
      step            = '0;
      phase_in        = phase_ff;
      remaining_in    = remaining_ff;
      address_kind_in = address_kind_ff;
      port_high_in    = port_high_ff;

      unique case (phase_ff)
         PH_NMETHODS: begin
            if (rx_byte == 8'd0) begin
               step.push_count = 2'd1;
               step.item0      = make_error(CAUSE_NO_METHODS);
               phase_in        = PH_GREET_VER;
            end else begin
               remaining_in = rx_byte;
               phase_in     = PH_METHODS;
            end
         end
         PH_METHODS: begin
            remaining_in = remaining_dec;
            // The method bytes themselves are not inspected; the reply always
            // selects no authentication.
            if (remaining_dec == 8'd0) begin
               step.push_count = 2'd2;
               step.item0 = make_item(KIND_REPLY, SOCKS_VER, ATYPE_IPV4, 16'd0,
                                      CAUSE_GREET_VER, 1'b0);
               step.item1 = make_item(KIND_REPLY, METHOD_NO_AUTH, ATYPE_IPV4, 16'd0,
                                      CAUSE_GREET_VER, 1'b1);
               phase_in   = PH_REQ_VER;
            end
         end
         PH_REQ_VER: begin
            if (rx_byte != SOCKS_VER) begin
               step.push_count = 2'd1;
               step.item0      = make_error(CAUSE_REQUEST);
               phase_in        = PH_GREET_VER;
            end else begin
               phase_in = PH_REQ_CMD;
            end
         end
         PH_REQ_CMD: begin
            if (rx_byte != CMD_CONNECT) begin
               step.push_count = 2'd1;
               step.item0      = make_error(CAUSE_REQUEST);
               phase_in        = PH_GREET_VER;
            end else begin
               phase_in = PH_REQ_RSV;
            end
         end
         PH_REQ_RSV: begin
            phase_in = PH_ATYP;
         end
         PH_ATYP: begin
            unique case (rx_byte)
               ATYP_BYTE_IPV4: begin
                  address_kind_in = ATYPE_IPV4;
                  remaining_in    = IPV4_ADDR_LEN;
                  phase_in        = PH_ADDR;
               end
               ATYP_BYTE_DOMAIN: begin
                  address_kind_in = ATYPE_DOMAIN;
                  phase_in        = PH_DLEN;
               end
               ATYP_BYTE_IPV6: begin
                  address_kind_in = ATYPE_IPV6;
                  remaining_in    = IPV6_ADDR_LEN;
                  phase_in        = PH_ADDR;
               end
               default: begin
                  step.push_count = 2'd1;
                  step.item0      = make_error(CAUSE_ATYP);
                  phase_in        = PH_GREET_VER;
               end
            endcase
         end
         PH_DLEN: begin
            if (rx_byte == 8'd0 || rx_byte > max_domain_len) begin
               step.push_count = 2'd1;
               step.item0      = make_error(CAUSE_DOMAIN_LEN);
               phase_in        = PH_GREET_VER;
            end else begin
               remaining_in = rx_byte;
               phase_in     = PH_ADDR;
            end
         end
         PH_ADDR: begin
            step.push_count = 2'd1;
            step.item0 = make_item(KIND_ADDR, rx_byte, address_kind_ff, 16'd0,
                                   CAUSE_GREET_VER, 1'b1);
            remaining_in = remaining_dec;
            if (remaining_dec == 8'd0) begin
               phase_in = PH_PORT_HI;
            end
         end
         PH_PORT_HI: begin
            port_high_in = rx_byte;
            phase_in     = PH_PORT_LO;
         end
         PH_PORT_LO: begin
            step.push_count = 2'd1;
            step.item0 = make_item(KIND_DONE, 8'd0, address_kind_ff,
                                   {port_high_ff, rx_byte}, CAUSE_GREET_VER, 1'b1);
            phase_in   = PH_GREET_VER;
         end
         default: begin
            // Greeting version; unused phase codes land here as well.
            if (rx_byte != SOCKS_VER) begin
               step.push_count = 2'd1;
               step.item0      = make_error(CAUSE_GREET_VER);
               phase_in        = PH_GREET_VER;
            end else begin
               phase_in = PH_NMETHODS;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_GREET_VER;
         remaining_ff    <= 8'd0;
         address_kind_ff <= ATYPE_IPV4;
         port_high_ff    <= 8'd0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         remaining_ff    <= remaining_in;
         address_kind_ff <= address_kind_in;
         port_high_ff    <= port_high_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/s5rp_queue.sv
// Result queue: up to two results in and one beat out a cycle while out_ready.
`default_nettype none

module s5rp_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire s5rp_pkg::step_type        step,
   input  wire logic                      out_ready,
   output s5rp_pkg::rsp_item_type         out_item,
   output s5rp_pkg::queue_status_type     status
);
   import s5rp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_item_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic [1:0]       push_n;
   logic             pop;

   function automatic logic [PTR_W-1:0] ptr_incr(logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign push_n      = push ? step.push_count : 2'd0;
   assign pop         = status.not_empty && out_ready;
   assign wr_ptr_next = ptr_incr(wr_ptr_ff);

   always_comb begin
      unique case (push_n)
         2'd1:    wr_ptr_in = wr_ptr_next;
         2'd2:    wr_ptr_in = ptr_incr(wr_ptr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_incr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   // Room is kept for the two reply beats of a single byte.
   assign status.has_room  = (count_ff <= CNT_W'(DEPTH - 2));
   assign status.not_empty = (count_ff != '0);
   assign out_item         = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entry_ff[wr_ptr_ff] <= step.item0;
      end
      if (push_n == 2'd2) begin
         entry_ff[wr_ptr_next] <= step.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/socks5_request_parser.sv
// A result beat is queued when its byte is accepted and offered on rsp from there.
// Throughput: one byte per cycle while the queue has room; the last method byte
// yields two reply beats, and the single read port of the result queue sends one
// beat per cycle while rsp is ready. Reset: clears the parse phase, counters and
// result queue, and sets the domain length limit to 255.
`default_nettype none

`include "socks5_request_parser_assert.svh"

module socks5_request_parser #(
   parameter int FIFO_DEPTH = 4
) (
   input wire logic  clock,
   input wire logic  reset,
   s5rp_req_if.sink  req_bus,
   s5rp_rsp_if.source rsp_bus,
   s5rp_csr_if.sink  csr_bus
);
   import s5rp_pkg::*;

   logic [7:0]       max_domain_len_ff;
   logic             accept;
   step_type         step;
   rsp_item_type     head;
   queue_status_type status;
   logic             pair_pushed;
   logic             error_shown;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = status.has_room;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_domain_len_ff <= DOMAIN_LEN_RESET;
      end else if (csr_bus.valid) begin
         max_domain_len_ff <= csr_bus.max_domain_len;
      end
   end

   s5rp_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .rx_byte        (req_bus.rx_byte),
      .max_domain_len (max_domain_len_ff),
      .step           (step)
   );

   s5rp_queue #(
      .DEPTH (FIFO_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .step      (step),
      .out_ready (rsp_bus.ready),
      .out_item  (head),
      .status    (status)
   );

   assign rsp_bus.valid       = status.not_empty;
   assign rsp_bus.kind        = head.kind;
   assign rsp_bus.data_byte   = head.data_byte;
   assign rsp_bus.addr_type   = head.addr_type;
   assign rsp_bus.target_port = head.target_port;
   assign rsp_bus.error_cause = head.error_cause;
   assign rsp_bus.last        = head.last;

   assign pair_pushed = accept && (step.push_count == 2'd2);
   assign error_shown = rsp_bus.valid && (rsp_bus.kind == KIND_ERROR);

   `S5RP_ASSERT_NEXT(a_reply_pair_shown, pair_pushed, rsp_bus.valid, "reply pair not offered")
   `S5RP_ASSERT_SAME(a_full_not_empty, !req_bus.ready, rsp_bus.valid, "stall with empty queue")
   `S5RP_ASSERT_SAME(a_error_is_last, error_shown, rsp_bus.last, "error beat not marked last")

endmodule

`default_nettype wire
